// ===== rtl/dtf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtf_pkg;

    // default sizes of the tile store
    localparam int DTF_MAX_TILE_WORDS = 256;
    localparam int DTF_MAX_KEPT_TILES = 64;

    // fixed field widths
    localparam int TILE_WORDS_W = 9;
    localparam int PIXEL_W      = 64;
    localparam int TILE_NUM_W   = 16;
    localparam int SLOT_OUT_W   = 6;
    localparam int KEPT_OUT_W   = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } dtf_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle
        logic scan;     // walk the kept slots
        logic finish;   // close the item, load a verdict if any
        logic cfg_wr;   // tile length write
    } dtf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;    // all kept slots compared
        logic need_result;  // item ends a tile or the strip
        logic out_free;     // output register can take a verdict
    } dtf_status_t;

endpackage

`default_nettype wire

// ===== rtl/dtf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 cfg_valid,
    input  dtf_pkg::dtf_status_t status,
    output dtf_pkg::dtf_cmd_t   cmd,
    output logic                in_stall,
    output logic                cfg_ready
);
    import dtf_pkg::*;

    dtf_state_t state_reg;
    dtf_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.need_result || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cfg_ready  = 1'b1;
                cmd.accept = in_valid;
                cmd.cfg_wr = cfg_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = !status.need_result || status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dtf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_datapath #(
    parameter int MAX_TILE_WORDS = dtf_pkg::DTF_MAX_TILE_WORDS,
    parameter int MAX_KEPT_TILES = dtf_pkg::DTF_MAX_KEPT_TILES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  dtf_pkg::dtf_cmd_t                cmd,
    output dtf_pkg::dtf_status_t             status,
    input  wire [dtf_pkg::TILE_WORDS_W-1:0]  tile_words,
    input  wire [dtf_pkg::PIXEL_W-1:0]       pixel,
    input  wire                              end_of_strip,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [dtf_pkg::TILE_NUM_W-1:0]   tile_number,
    output logic                             is_duplicate,
    output logic [dtf_pkg::SLOT_OUT_W-1:0]   match_slot,
    output logic [dtf_pkg::KEPT_OUT_W-1:0]   kept_count,
    output logic                             store_full,
    output logic                             partial_tile,
    output logic                             strip_done
);
    import dtf_pkg::*;

    localparam int PW    = (MAX_TILE_WORDS > 1) ? $clog2(MAX_TILE_WORDS) : 1;
    localparam int LW    = $clog2(MAX_TILE_WORDS + 1);
    localparam int CW    = (LW > TILE_WORDS_W) ? LW : TILE_WORDS_W;
    localparam int SW    = (MAX_KEPT_TILES > 1) ? $clog2(MAX_KEPT_TILES) : 1;
    localparam int KW    = $clog2(MAX_KEPT_TILES + 1);
    localparam int AW    = SW + PW;
    localparam int DEPTH = MAX_KEPT_TILES * (2 ** PW);

    // tile store: one row of 2**PW words per slot
    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // strip state
    logic [LW-1:0]             len_reg;
    logic [PW-1:0]             wpos_reg;
    logic [KW-1:0]             kept_reg;
    logic [TILE_NUM_W-1:0]     tile_cnt_reg;
    logic [MAX_KEPT_TILES-1:0] match_reg;

    // item state
    logic [PIXEL_W-1:0] px_reg;
    logic               last_reg;
    logic [PW-1:0]      ipos_reg;
    logic [KW-1:0]      rd_slot_reg;
    logic               cmp_valid_reg;
    logic [SW-1:0]      cmp_slot_reg;
    logic               found_reg;
    logic [SW-1:0]      found_slot_reg;

    // output register
    logic                  out_valid_reg;
    logic [TILE_NUM_W-1:0] tile_number_reg;
    logic                  is_duplicate_reg;
    logic [SLOT_OUT_W-1:0] match_slot_reg;
    logic [KEPT_OUT_W-1:0] kept_count_reg;
    logic                  store_full_reg;
    logic                  partial_tile_reg;
    logic                  strip_done_reg;

    logic [CW-1:0] tw_ext;
    logic [LW-1:0] len_next;
    logic [PW-1:0] ipos_next;
    logic          kept_room;
    logic          issue;
    logic          hit;
    logic          miss;
    logic          tile_end;
    logic [KW-1:0] kept_new;
    logic          dup;
    logic          full;
    logic          out_take;

    // tile length clamp on a register write
    always_comb
    begin
        tw_ext = CW'(tile_words);
        if (tw_ext == '0)
        begin
            len_next = LW'(1);
        end
        else if (tw_ext > CW'(MAX_TILE_WORDS))
        begin
            len_next = LW'(MAX_TILE_WORDS);
        end
        else
        begin
            len_next = tw_ext[LW-1:0];
        end
    end

    // word position of the incoming pixel
    assign ipos_next = (LW'(wpos_reg) >= len_reg) ? '0 : wpos_reg;
    assign kept_room = kept_reg < KW'(MAX_KEPT_TILES);

    // scan: issue one read per cycle, compare in the next cycle
    assign issue = cmd.scan && (rd_slot_reg < kept_reg);
    assign hit   = cmp_valid_reg && match_reg[cmp_slot_reg] && (rd_data_reg == px_reg);
    assign miss  = cmp_valid_reg && match_reg[cmp_slot_reg] && (rd_data_reg != px_reg);

    // verdict
    assign tile_end = (LW'(ipos_reg) + LW'(1)) == len_reg;
    assign dup      = found_reg;
    assign full     = !found_reg && !kept_room;
    assign kept_new = (!found_reg && kept_room) ? kept_reg + KW'(1) : kept_reg;
    assign out_take = out_valid_reg && !out_stall;

    assign status.scan_done   = (rd_slot_reg == kept_reg) && !cmp_valid_reg;
    assign status.need_result = tile_end || last_reg;
    assign status.out_free    = !out_valid_reg || !out_stall;

    // tile store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && kept_room)
        begin
            mem[{kept_reg[SW-1:0], ipos_next}] <= pixel;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{rd_slot_reg[SW-1:0], ipos_reg}];
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            px_reg   <= pixel;
            last_reg <= end_of_strip;
            ipos_reg <= ipos_next;
        end
        if (issue)
        begin
            cmp_slot_reg <= rd_slot_reg[SW-1:0];
        end
        if (hit && !found_reg)
        begin
            found_slot_reg <= cmp_slot_reg;
        end
    end

    // scan control and strip state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LW'(1);
            wpos_reg      <= '0;
            kept_reg      <= '0;
            tile_cnt_reg  <= '0;
            match_reg     <= '1;
            rd_slot_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= issue;
            if (cmd.cfg_wr)
            begin
                len_reg      <= len_next;
                wpos_reg     <= '0;
                kept_reg     <= '0;
                tile_cnt_reg <= '0;
                match_reg    <= '1;
            end
            if (cmd.accept)
            begin
                rd_slot_reg <= '0;
                found_reg   <= 1'b0;
            end
            if (issue)
            begin
                rd_slot_reg <= rd_slot_reg + KW'(1);
            end
            if (miss)
            begin
                match_reg[cmp_slot_reg] <= 1'b0;
            end
            if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                priority if (last_reg)
                begin
                    wpos_reg     <= '0;
                    kept_reg     <= '0;
                    tile_cnt_reg <= '0;
                    match_reg    <= '1;
                end
                else if (tile_end)
                begin
                    wpos_reg  <= '0;
                    kept_reg  <= kept_new;
                    match_reg <= '1;
                    if (tile_cnt_reg != '1)
                    begin
                        tile_cnt_reg <= tile_cnt_reg + TILE_NUM_W'(1);
                    end
                end
                else
                begin
                    wpos_reg <= ipos_reg + PW'(1);
                end
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish && status.need_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish && status.need_result)
        begin
            tile_number_reg <= tile_cnt_reg;
            if (tile_end)
            begin
                is_duplicate_reg <= dup;
                match_slot_reg   <= dup ? SLOT_OUT_W'(found_slot_reg) : '0;
                kept_count_reg   <= KEPT_OUT_W'(kept_new);
                store_full_reg   <= full;
                partial_tile_reg <= 1'b0;
                strip_done_reg   <= last_reg;
            end
            else
            begin
                is_duplicate_reg <= 1'b0;
                match_slot_reg   <= '0;
                kept_count_reg   <= KEPT_OUT_W'(kept_reg);
                store_full_reg   <= 1'b0;
                partial_tile_reg <= 1'b1;
                strip_done_reg   <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign tile_number  = tile_number_reg;
    assign is_duplicate = is_duplicate_reg;
    assign match_slot   = match_slot_reg;
    assign kept_count   = kept_count_reg;
    assign store_full   = store_full_reg;
    assign partial_tile = partial_tile_reg;
    assign strip_done   = strip_done_reg;

endmodule

`default_nettype wire

// ===== rtl/duplicate_tile_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  tile_words
// in        in_valid/in_stall    pixel, end_of_strip
// out       out_valid/out_stall  tile_number, is_duplicate, match_slot,
//                                kept_count, store_full, partial_tile, strip_done
//
// For each pixel the single read port of the tile store is walked once
// per kept slot.
// A verdict waits in the output register; the next pixel is taken meanwhile,
// and its finish step holds (in_stall high) only while an earlier verdict
// is still stalled and this pixel needs a verdict of its own.
// Reset leaves the tile length at 1 and an empty store; no clearing pass.
// A tile_words write restarts the strip.

module duplicate_tile_filter #(
    parameter int MAX_TILE_WORDS = dtf_pkg::DTF_MAX_TILE_WORDS,
    parameter int MAX_KEPT_TILES = dtf_pkg::DTF_MAX_KEPT_TILES
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [dtf_pkg::TILE_WORDS_W-1:0]  tile_words,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [dtf_pkg::PIXEL_W-1:0]       pixel,
    input  wire                              end_of_strip,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [dtf_pkg::TILE_NUM_W-1:0]   tile_number,
    output logic                             is_duplicate,
    output logic [dtf_pkg::SLOT_OUT_W-1:0]   match_slot,
    output logic [dtf_pkg::KEPT_OUT_W-1:0]   kept_count,
    output logic                             store_full,
    output logic                             partial_tile,
    output logic                             strip_done
);
    import dtf_pkg::*;

    dtf_cmd_t    cmd;
    dtf_status_t status;

    // sequencer
    dtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    // tile store, match flags, verdict
    dtf_datapath #(
        .MAX_TILE_WORDS (MAX_TILE_WORDS),
        .MAX_KEPT_TILES (MAX_KEPT_TILES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .tile_words   (tile_words),
        .pixel        (pixel),
        .end_of_strip (end_of_strip),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tile_number  (tile_number),
        .is_duplicate (is_duplicate),
        .match_slot   (match_slot),
        .kept_count   (kept_count),
        .store_full   (store_full),
        .partial_tile (partial_tile),
        .strip_done   (strip_done)
    );

endmodule

`default_nettype wire

// ===== rtl/dtf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtf_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              out_valid,
    input wire                              out_stall,
    input wire [dtf_pkg::TILE_NUM_W-1:0]    tile_number,
    input wire                              is_duplicate,
    input wire [dtf_pkg::SLOT_OUT_W-1:0]    match_slot,
    input wire                              store_full,
    input wire                              partial_tile,
    input wire                              strip_done
);

    // a stalled verdict stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tile_number)
            && $stable(is_duplicate) && $stable(match_slot))
        else $error("verdict changed while stalled");

    // a duplicate is neither a full-store drop nor a partial tile
    a_dup_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_duplicate |-> !store_full && !partial_tile)
        else $error("duplicate verdict with store_full or partial_tile");

    // a partial tile always closes the strip
    a_partial: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && partial_tile |-> strip_done && !is_duplicate)
        else $error("partial tile without strip end");

    // new tiles report slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_duplicate |-> match_slot == '0)
        else $error("match_slot set on a new tile");

endmodule

bind duplicate_tile_filter dtf_checker u_dtf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tile_number  (tile_number),
    .is_duplicate (is_duplicate),
    .match_slot   (match_slot),
    .store_full   (store_full),
    .partial_tile (partial_tile),
    .strip_done   (strip_done)
);

`default_nettype wire
